FILE: rtl/multi_tap_echo_reverb_macros.svh
// Assertion macros used by the echo block top level.
`ifndef MULTI_TAP_ECHO_REVERB_MACROS_SVH
`define MULTI_TAP_ECHO_REVERB_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MTER_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define MTER_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTER_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define MTER_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/mter_pkg.sv
// Package: register map, reset values and shared types of the echo block.
`timescale 1ns / 1ps
package mter_pkg;

  localparam int REG_BITS     = 15;
  localparam int NUM_REGS     = 8;
  localparam int CFG_IDX_BITS = 4;
  localparam int TAP_MAX      = 4;
  localparam int TAP_SEL_BITS = 2;
  localparam int Q15_SHIFT    = 15;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP0_DELAY = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP0_GAIN  = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP1_DELAY = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP1_GAIN  = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP2_DELAY = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP2_GAIN  = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP3_DELAY = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP3_GAIN  = 4'd7;

  // Reset values, per tap
  localparam logic [REG_BITS-1:0] DELAY_RESET [TAP_MAX] = '{
    15'd8000, 15'd11025, 15'd22050, 15'd32000
  };
  localparam logic [REG_BITS-1:0] GAIN_RESET [TAP_MAX] = '{
    15'd4096, 15'd4096, 15'd2048, 15'd1024
  };

  // Channel select of the shared multiplier
  localparam logic CHAN_LEFT  = 1'b0;
  localparam logic CHAN_RIGHT = 1'b1;

  typedef struct packed {
    logic mul_en;
    logic chan;
  } mter_mul_ctrl_t;

endpackage

FILE: rtl/mter_in_if.sv
// Interface: stereo dry sample request channel.
`timescale 1ns / 1ps
interface mter_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_left;
  logic signed [SAMPLE_BITS-1:0] in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

FILE: rtl/mter_out_if.sv
// Interface: stereo mixed sample result channel.
`timescale 1ns / 1ps
interface mter_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

FILE: rtl/mter_mix.sv
// Shared tap unit: registered gain multiply, dry-sample add, Q15 truncation and saturation.
`timescale 1ns / 1ps
module mter_mix import mter_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  mter_mul_ctrl_t                ctrl,
  input  logic        [REG_BITS-1:0]    coef,
  input  logic signed [SAMPLE_BITS-1:0] entry_l,
  input  logic signed [SAMPLE_BITS-1:0] entry_r,
  input  logic signed [SAMPLE_BITS-1:0] sample_l,
  input  logic signed [SAMPLE_BITS-1:0] sample_r,
  output logic signed [SAMPLE_BITS-1:0] mixed
);

  localparam int PW = SAMPLE_BITS + REG_BITS + 1;
  localparam int QW = SAMPLE_BITS + 2;
  localparam logic signed [QW-1:0] SAT_HI = QW'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [QW-1:0] SAT_LO = ~SAT_HI;

  logic signed [PW-1:0]          prod;
  logic                          chan_q;
  logic signed [SAMPLE_BITS-1:0] entry_sel;
  logic signed [SAMPLE_BITS-1:0] sample_sel;
  logic signed [QW-1:0]          q_floor;
  logic signed [QW-1:0]          q;
  logic                          frac_nz;

  assign entry_sel = (ctrl.chan == CHAN_RIGHT) ? entry_r : entry_l;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod   <= $signed({1'b0, coef}) * entry_sel;
      chan_q <= ctrl.chan;
    end
  end

  // floor((prod + sample*2^15) / 2^15), then bump toward zero when that is negative with a nonzero remainder
  assign sample_sel = (chan_q == CHAN_RIGHT) ? sample_r : sample_l;
  assign q_floor    = QW'(prod >>> Q15_SHIFT) + QW'(sample_sel);
  assign frac_nz    = |prod[Q15_SHIFT-1:0];
  assign q          = q_floor + {{(QW-1){1'b0}}, (q_floor[QW-1] & frac_nz)};

  always_comb begin
    if (q > SAT_HI) begin
      mixed = SAT_HI[SAMPLE_BITS-1:0];
    end else if (q < SAT_LO) begin
      mixed = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      mixed = q[SAMPLE_BITS-1:0];
    end
  end

endmodule

FILE: rtl/multi_tap_echo_reverb.sv
// Top level: stereo multi-tap feedback echo with a circular sample store.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-------------------------------
//  din       | in  | valid / ready      | in_left, in_right (signed)
//  dout      | out | valid / ready      | out_left, out_right (signed)
//  cfg       | in  | cfg_we (no stall)  | cfg_index, cfg_data
//
//  Each tap steps S_TAP, S_MUL_L, S_MUL_R, S_WRITE; then S_HEAD, S_OUT. S_TAP
//  repeats per whole STORE_DEPTH in a tap delay (never when depth >= 32768).
//  Each tap costs a store read, two passes through the single multiplier
//  (left, right) and a store write; the single read port sets the rest.
//  Reset: a clearing pass zeroes every store entry, din.ready low.
//  A result waiting in the output register does not block the next request;
//  only its own output step waits for the slot.
`timescale 1ns / 1ps
`include "multi_tap_echo_reverb_macros.svh"
module multi_tap_echo_reverb import mter_pkg::*; #(
  parameter int STORE_DEPTH = 32768,
  parameter int TAP_COUNT   = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]     cfg_data,
  mter_in_if.sink                 din,
  mter_out_if.source              dout
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int DW     = (ADDR_W > REG_BITS) ? ADDR_W : REG_BITS;
  localparam int SB     = SAMPLE_BITS;
  localparam logic [DW:0]       DEPTH_C  = (DW + 1)'(STORE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [TAP_SEL_BITS-1:0] LAST_TAP = TAP_SEL_BITS'(TAP_COUNT - 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_TAP   = 8'b0000_0100,
    S_MUL_L = 8'b0000_1000,
    S_MUL_R = 8'b0001_0000,
    S_WRITE = 8'b0010_0000,
    S_HEAD  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // config registers
  logic [REG_BITS-1:0] tap_delay [TAP_MAX];
  logic [REG_BITS-1:0] tap_gain  [TAP_MAX];

  // control
  logic [TAP_SEL_BITS-1:0] tap_idx;
  logic [TAP_SEL_BITS-1:0] tap_sel;
  logic [ADDR_W-1:0]       clr_addr;
  logic [ADDR_W-1:0]       head;
  logic                    out_valid;
  logic                    last_tap;
  logic                    slot_free;
  logic                    accept;
  logic                    load;

  // datapath
  logic signed [SB-1:0]  sl, sr;
  logic [DW-1:0]         dly;
  logic [REG_BITS-1:0]   g;
  logic [REG_BITS-1:0]   gain_sel;
  logic                  dly_over;
  logic [DW+1:0]         diff;
  logic [DW+1:0]         wrapped;
  logic [ADDR_W-1:0]     addr_calc;
  logic [ADDR_W-1:0]     tap_addr;
  logic signed [SB-1:0]  res_l;
  logic signed [SB-1:0]  mixed;
  logic signed [SB-1:0]  ol, orr;
  mter_mul_ctrl_t        mix_ctrl;

  // store
  logic [2*SB-1:0]   mem [STORE_DEPTH];
  logic [2*SB-1:0]   rd_data;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ADDR_W-1:0] mem_waddr;
  logic [2*SB-1:0]   mem_wdata;
  logic              mem_we;
  logic signed [SB-1:0] rd_l, rd_r;

  logic signed [SB:0] hsum;
  logic signed [SB:0] hrnd;

  assign din.ready = (state == S_IDLE);
  assign accept    = din.valid && din.ready;
  assign last_tap  = (tap_idx == LAST_TAP);
  assign slot_free = !out_valid || dout.ready;

  assign dout.valid     = out_valid;
  assign dout.out_left  = ol;
  assign dout.out_right = orr;

  // --- configuration registers -------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAP_MAX; i++) begin
        tap_delay[i] <= DELAY_RESET[i];
        tap_gain[i]  <= GAIN_RESET[i];
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAP0_DELAY: tap_delay[0] <= cfg_data;
        REG_TAP0_GAIN:  tap_gain[0]  <= cfg_data;
        REG_TAP1_DELAY: tap_delay[1] <= cfg_data;
        REG_TAP1_GAIN:  tap_gain[1]  <= cfg_data;
        REG_TAP2_DELAY: tap_delay[2] <= cfg_data;
        REG_TAP2_GAIN:  tap_gain[2]  <= cfg_data;
        REG_TAP3_DELAY: tap_delay[3] <= cfg_data;
        REG_TAP3_GAIN:  tap_gain[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // --- sequencer ---------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == LAST_IDX) state_next = S_IDLE;
      S_IDLE:  if (din.valid) state_next = S_TAP;
      S_TAP:   if (!dly_over) state_next = S_MUL_L;
      S_MUL_L: state_next = S_MUL_R;
      S_MUL_R: state_next = S_WRITE;
      S_WRITE: state_next = last_tap ? S_HEAD : S_TAP;
      S_HEAD:  state_next = S_OUT;
      S_OUT:   if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      tap_idx   <= '0;
      clr_addr  <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_WRITE) begin
        tap_idx <= last_tap ? '0 : tap_idx + 1'b1;
      end
      if (state == S_OUT && slot_free) begin
        head      <= (head == LAST_IDX) ? '0 : head + 1'b1;
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --- tap setup: delay and effective gain of the next tap ----------------
  // 32767*gain/32768 truncated is gain-1 for any nonzero 15-bit gain
  assign tap_sel  = (state == S_IDLE) ? '0 : tap_idx + 1'b1;
  assign gain_sel = tap_gain[tap_sel];
  assign load     = (state == S_IDLE) || (state == S_WRITE && !last_tap);
  assign dly_over = ({1'b0, dly} >= DEPTH_C);

  // head - delay, wrapped into the store
  assign diff      = {2'b00, DW'(head)} - {2'b00, dly};
  assign wrapped   = diff[DW+1] ? (diff + {1'b0, DEPTH_C}) : diff;
  assign addr_calc = wrapped[ADDR_W-1:0];

  // truncated (a + b) / 2
  function automatic logic signed [SB-1:0] hsum_half(input logic signed [SB-1:0] a,
                                                    input logic signed [SB-1:0] b);
    logic signed [SB:0] s;
    logic signed [SB:0] r;
    s = {a[SB-1], a} + {b[SB-1], b};
    r = s + {{SB{1'b0}}, s[SB]};
    return r[SB:1];
  endfunction

  always_ff @(posedge clk) begin
    if (accept) begin
      sl <= din.in_left;
      sr <= din.in_right;
    end
    if (load) begin
      dly <= DW'(tap_delay[tap_sel]);
      g   <= (gain_sel == '0) ? '0 : gain_sel - 1'b1;
    end else if (state == S_TAP && dly_over) begin
      // delay beyond the store: peel off one depth per cycle
      dly <= dly - DEPTH_C[DW-1:0];
    end
    if (state == S_TAP && !dly_over) begin
      tap_addr <= addr_calc;
    end
    if (state == S_MUL_R) begin
      res_l <= mixed;
    end
    if (state == S_OUT && slot_free) begin
      ol  <= hsum_half(sl, rd_l);
      orr <= hsum_half(sr, rd_r);
    end
  end

  // left-channel half sum, kept for the output check below
  assign hsum = {sl[SB-1], sl} + {rd_l[SB-1], rd_l};
  assign hrnd = hsum + {{SB{1'b0}}, hsum[SB]};

  // --- shared tap unit ---------------------------------------------------
  always_comb begin
    mix_ctrl.mul_en = (state == S_MUL_L) || (state == S_MUL_R);
    mix_ctrl.chan   = (state == S_MUL_R) ? CHAN_RIGHT : CHAN_LEFT;
  end

  mter_mix #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mix (
    .clk      (clk),
    .ctrl     (mix_ctrl),
    .coef     (g),
    .entry_l  (rd_l),
    .entry_r  (rd_r),
    .sample_l (sl),
    .sample_r (sr),
    .mixed    (mixed)
  );

  // --- echo store: one write, one registered read per cycle --------------
  // The read address is held on the tap entry through both multiplies and
  // on head through the output step so rd_data stays put.
  always_comb begin
    if (state == S_TAP) begin
      mem_raddr = addr_calc;
    end else if (state == S_MUL_L || state == S_MUL_R) begin
      mem_raddr = tap_addr;
    end else begin
      mem_raddr = head;
    end
  end

  assign mem_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : tap_addr;
  assign mem_wdata = (state == S_CLEAR) ? '0 : {mixed, res_l};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  assign rd_l = rd_data[SB-1:0];
  assign rd_r = rd_data[2*SB-1:SB];

  // --- checks ------------------------------------------------------------
  `MTER_ASSERT_NEXT(a_accept_starts_tap0, clk, rst, din.valid && din.ready, state == S_TAP && tap_idx == '0, "request did not start at the first tap")
  `MTER_ASSERT_IMP(a_write_after_mul, clk, rst, state == S_WRITE, $past(state) == S_MUL_R, "tap write without both multiplies")
  `MTER_ASSERT_IMP(a_head_after_last_tap, clk, rst, state == S_HEAD, $past(state) == S_WRITE && $past(tap_idx) == LAST_TAP, "head read before all taps were written")
  `MTER_ASSERT_IMP(a_result_from_out, clk, rst, $rose(dout.valid), $past(state) == S_OUT && $past(hrnd[SB:1]) == dout.out_left, "result raised outside the output step")

endmodule
